@@ sv/encoder_edge_speed_meter_macros.svh @@
// ----------------------------------------------------------------------------
// Encoder edge speed meter assertion macros
// Shorthand for clocked implication checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ENCODER_EDGE_SPEED_METER_MACROS_SVH
`define ENCODER_EDGE_SPEED_METER_MACROS_SVH

// same-cycle implication
`define EESM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eesm same-cycle check failed");

// next-cycle implication
`define EESM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eesm next-cycle check failed");

`endif

@@ sv/eesm_pkg.sv @@
// ----------------------------------------------------------------------------
// eesm_pkg
// Widths, register indexes, reset values and divider control types.
// ----------------------------------------------------------------------------
`default_nettype none

package eesm_pkg;

    localparam int W_STAMP = 26;
    localparam int W_INTV  = 27;
    localparam int W_HZ    = 26;
    localparam int W_LINES = 16;
    localparam int W_RPM   = 32;
    localparam int W_DEN   = W_INTV + W_LINES;
    localparam int W_CFG   = 27;
    localparam int W_IDX   = 2;

    localparam int DIV_STEPS = W_RPM;
    localparam int W_DCNT    = $clog2(DIV_STEPS);

    localparam logic [5:0] RPM_SECONDS = 6'd60;

    localparam logic [W_IDX-1:0] REG_COUNT_MODULUS = 2'd0;
    localparam logic [W_IDX-1:0] REG_CLOCK_HZ      = 2'd1;
    localparam logic [W_IDX-1:0] REG_LINES_CH0     = 2'd2;
    localparam logic [W_IDX-1:0] REG_LINES_CH1     = 2'd3;

    localparam logic [W_INTV-1:0] RST_COUNT_MODULUS = 27'd50000000;
    localparam logic [W_HZ-1:0]   RST_CLOCK_HZ      = 26'd50000000;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

@@ sv/eesm_edge_if.sv @@
// ----------------------------------------------------------------------------
// eesm_edge_if
// Encoder edge channel: valid/ready handshake with channel and timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface eesm_edge_if import eesm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               channel;
    logic [W_STAMP-1:0] stamp;

    modport source (output valid, output channel, output stamp, input ready);
    modport sink   (input valid, input channel, input stamp, output ready);
endinterface

`default_nettype wire

@@ sv/eesm_result_if.sv @@
// ----------------------------------------------------------------------------
// eesm_result_if
// Speed result channel: valid/ready handshake with interval and RPM.
// ----------------------------------------------------------------------------
`default_nettype none

interface eesm_result_if import eesm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              out_channel;
    logic [W_INTV-1:0] interval_clocks;
    logic              interval_valid;
    logic [W_RPM-1:0]  speed_rpm;
    logic              divide_fault;

    modport source (output valid, output out_channel, output interval_clocks,
                    output interval_valid, output speed_rpm, output divide_fault,
                    input ready);
    modport sink   (input valid, input out_channel, input interval_clocks,
                    input interval_valid, input speed_rpm, input divide_fault,
                    output ready);
endinterface

`default_nettype wire

@@ sv/encoder_edge_speed_meter.sv @@
// ----------------------------------------------------------------------------
// encoder_edge_speed_meter
// Two-channel encoder period meter: interval since last edge and RPM.
// ----------------------------------------------------------------------------
// Usage:
//   i_edge   - one transaction per encoder edge: channel and the down-counting
//              timer value latched at that edge.
//   o_result - one transaction per edge: channel, interval in clocks, a valid
//              flag (set once the channel has an earlier edge), RPM and a fault flag
//              for a zero interval*lines product.
//   i_cfg_*  - register writes (modulus, clock rate, lines per channel); write
//              only while the block is idle.
// Timing: an edge is taken only when the sequencer is idle. A divided result
//   reaches o_result through the product, the check, 32 divider steps, the
//   quotient latch and the hand-off into the output register; results that
//   skip the divide (first edge, zero divisor) go from the check straight to
//   the hand-off. A new edge is not taken until the bit-serial divider and the
//   hand-off are through with the last one.
// Reset: per-channel stamps and edge history clear, registers return to
//   modulus 50e6, clock 50e6, zero lines; the output register empties.
// Stall: the output register holds its transaction until taken; the next edge
//   is still accepted and runs, parking in the hand-off state if the output
//   is still occupied when its result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_edge_speed_meter import eesm_pkg::*; #(
    parameter int CHANNELS = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    eesm_edge_if.sink             i_edge,
    eesm_result_if.source         o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [W_IDX-1:0] i_cfg_index,
    input  wire logic [W_CFG-1:0] i_cfg_wdata
);

    `include "encoder_edge_speed_meter_macros.svh"

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    // configuration
    logic [W_INTV-1:0]  r_modulus;
    logic [W_HZ-1:0]    r_clock_hz;
    logic [W_LINES-1:0] r_lines0;
    logic [W_LINES-1:0] r_lines1;

    // per-channel edge history
    logic [W_STAMP-1:0] r_last [CHANNELS];
    logic [CHANNELS-1:0] r_have_prev;
    logic [CHANNELS-1:0] r_valid_mark;

    // sequencer and working registers
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic               r_ch;
    logic               r_ch_ok;
    logic               r_vld;
    logic [W_INTV-1:0]  r_intv;
    logic [W_DEN-1:0]   r_den;
    logic [W_RPM-1:0]   r_num;
    logic [W_RPM-1:0]   r_rpm;
    logic               r_flt;

    // output register
    logic               r_out_valid;
    logic               r_o_ch;
    logic [W_INTV-1:0]  r_o_intv;
    logic               r_o_vld;
    logic [W_RPM-1:0]   r_o_rpm;
    logic               r_o_flt;

    logic               w_accept;
    logic               w_ch_ok;
    logic [CH_W-1:0]    w_idx;
    logic [W_STAMP-1:0] w_prev;
    logic [W_INTV-1:0]  w_intv;
    logic [W_LINES-1:0] w_lines;
    logic               w_slot_free;
    logic               w_load_out;

    t_div_ctl           w_div_ctl;
    t_div_stat          w_div_stat;
    logic [W_RPM-1:0]   w_quot;

    assign i_edge.ready = (r_state == S_IDLE);
    assign w_accept     = i_edge.valid && i_edge.ready;
    assign w_idx        = CH_W'(i_edge.channel);
    assign w_ch_ok      = (CH_W'(i_edge.channel) < CH_W'(CHANNELS)) || (CHANNELS > 1);
    assign w_prev       = w_ch_ok ? r_last[w_idx] : '0;

    // interval in clocks; down-counter wraps at the configured modulus
    always_comb begin
        if (w_prev > i_edge.stamp) begin
            w_intv = {1'b0, w_prev - i_edge.stamp};
        end else begin
            w_intv = r_modulus + {1'b0, w_prev} - {1'b0, i_edge.stamp};
        end
    end

    assign w_lines = r_ch ? r_lines1 : r_lines0;

    // output register is free or being drained this cycle
    assign w_slot_free = !r_out_valid || o_result.ready;
    assign w_load_out  = (r_state == S_HOLD) && w_slot_free;

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= RST_COUNT_MODULUS;
            r_clock_hz <= RST_CLOCK_HZ;
            r_lines0   <= '0;
            r_lines1   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COUNT_MODULUS: r_modulus  <= i_cfg_wdata[W_INTV-1:0];
                REG_CLOCK_HZ:      r_clock_hz <= i_cfg_wdata[W_HZ-1:0];
                REG_LINES_CH0:     r_lines0   <= i_cfg_wdata[W_LINES-1:0];
                REG_LINES_CH1:     r_lines1   <= i_cfg_wdata[W_LINES-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---- channel history ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= '0;
            end
            r_have_prev  <= '0;
            r_valid_mark <= '0;
        end else if (w_accept && w_ch_ok) begin
            r_last[w_idx]       <= i_edge.stamp;
            r_have_prev[w_idx]  <= 1'b1;
            r_valid_mark[w_idx] <= r_valid_mark[w_idx] | r_have_prev[w_idx];
        end
    end

    // ---- sequencer ----
    always_comb begin
        n_state         = r_state;
        w_div_ctl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_vld && (r_den != '0)) begin
                    w_div_ctl.start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- working registers ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_ch    <= i_edge.channel;
                    r_ch_ok <= w_ch_ok;
                    r_intv  <= w_ch_ok ? w_intv : '0;
                    r_vld   <= w_ch_ok && (r_valid_mark[w_idx] | r_have_prev[w_idx]);
                end
            end
            S_MUL: begin
                r_den <= W_DEN'(r_intv) * W_DEN'(w_lines);
                r_num <= W_RPM'(r_clock_hz) * W_RPM'(RPM_SECONDS);
            end
            S_CHK: begin
                r_rpm <= '0;
                r_flt <= r_vld && (r_den == '0);
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    r_rpm <= w_quot;
                end
            end
            default: begin
            end
        endcase
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_ch   <= r_ch;
            r_o_intv <= r_intv;
            r_o_vld  <= r_vld;
            r_o_rpm  <= r_rpm;
            r_o_flt  <= r_flt;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.out_channel     = r_o_ch;
    assign o_result.interval_clocks = r_o_intv;
    assign o_result.interval_valid  = r_o_vld;
    assign o_result.speed_rpm       = r_o_rpm;
    assign o_result.divide_fault    = r_o_flt;

    // shared bit-serial divider
    eesm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // ---- checks ----
    `EESM_ASSERT_NEXT(a_accept_to_mul, i_clk, i_rst_n, w_accept, r_state == S_MUL)
    `EESM_ASSERT_IMP(a_fault_zero_rpm, i_clk, i_rst_n, r_out_valid && r_o_flt, r_o_rpm == '0)
    `EESM_ASSERT_IMP(a_invalid_quiet, i_clk, i_rst_n, r_out_valid && !r_o_vld, (r_o_rpm == '0) && !r_o_flt)
    `EESM_ASSERT_IMP(a_div_in_div_state, i_clk, i_rst_n, w_div_stat.busy, r_state == S_DIV)
    `EESM_ASSERT_IMP(a_bad_channel_zero, i_clk, i_rst_n, (r_state == S_HOLD) && !r_ch_ok, (r_intv == '0) && !r_vld)

endmodule

`default_nettype wire

@@ sv/eesm_div.sv @@
// ----------------------------------------------------------------------------
// eesm_div
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module eesm_div import eesm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [W_RPM-1:0] i_num,
    input  wire logic [W_DEN-1:0] i_den,
    output t_div_stat             o_stat,
    output logic [W_RPM-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [W_DCNT-1:0] r_cnt;
    logic [W_RPM-1:0]  r_rem;
    logic [W_RPM-1:0]  r_q;
    logic [W_DEN-1:0]  r_den;

    logic [W_RPM:0]    w_sh;
    logic [W_DEN:0]    w_diff;
    logic              w_take;

    // remainder never exceeds a prefix of the 32-bit numerator
    always_comb begin
        w_sh   = {r_rem, r_q[W_RPM-1]};
        w_diff = {{(W_DEN-W_RPM){1'b0}}, w_sh} - {1'b0, r_den};
        w_take = !w_diff[W_DEN];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == W_DCNT'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_take ? w_diff[W_RPM-1:0] : w_sh[W_RPM-1:0];
            r_q   <= {r_q[W_RPM-2:0], w_take};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

`default_nettype wire
